/* rtl/core/spmv_pkg.sv */
// ----------------------------------------------------------------------------
// spmv_pkg
// Shared widths, request codes and inter-module structs for the CSR row
// accumulator.
// ----------------------------------------------------------------------------
package spmv_pkg;

    localparam int IDX_W      = 12;
    localparam int VAL_W      = 32;
    localparam int ACC_W      = 48;
    localparam int PROD_W     = 64;
    localparam int FRAC_W     = 16;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_NZ   = 1'b1;

    typedef struct packed {
        logic                    valid;
        logic                    last;
        logic signed [VAL_W-1:0] val;
        logic signed [VAL_W-1:0] vec;
    } t_mac_req;

    typedef struct packed {
        logic [IDX_W-1:0]        row_index;
        logic signed [VAL_W-1:0] row_sum;
        logic                    overflow;
    } t_result;

endpackage

/* rtl/core/spmv_vec_store.sv */
// ----------------------------------------------------------------------------
// spmv_vec_store
// Input register, address folding onto the store depth and the dense vector
// memory. Loads write the memory, nonzeros read their vector element.
// ----------------------------------------------------------------------------
module spmv_vec_store import spmv_pkg::*; #(
    parameter int VECTOR_DEPTH = 4096
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic                    i_req_type,
    input  logic [IDX_W-1:0]        i_index,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_last,
    output t_mac_req                o_req,
    output logic                    o_s0_pend
);

    localparam int AW    = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int SH    = 24;
    localparam int RW    = 25;
    localparam int QW    = IDX_W + RW;
    localparam int MW    = IDX_W + 17;
    localparam int RECIP = ((1 << SH) + VECTOR_DEPTH - 1) / VECTOR_DEPTH;

    logic                    r_valid;
    logic                    r_type;
    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        r_q;
    logic signed [VAL_W-1:0] r_val;
    logic                    r_last;

    logic                    r1_valid;
    logic                    r1_last;
    logic signed [VAL_W-1:0] r1_val;
    logic signed [VAL_W-1:0] r_vec;

    logic [VAL_W-1:0]        r_vmem [VECTOR_DEPTH];

    logic [QW-1:0]           w_qprod;
    logic [MW-1:0]           w_qd;
    logic [MW-1:0]           w_rem;
    logic [AW-1:0]           w_addr;

    assign w_qprod = QW'(i_index) * QW'(RECIP);
    assign w_qd    = MW'(r_q) * MW'(VECTOR_DEPTH);
    assign w_rem   = MW'(r_idx) - w_qd;
    assign w_addr  = w_rem[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r1_valid <= 1'b0;
        end else begin
            r_valid  <= i_valid;
            r1_valid <= r_valid && (r_type == REQ_NZ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_type <= i_req_type;
            r_idx  <= i_index;
            r_q    <= w_qprod[SH+IDX_W-1:SH];
            r_val  <= i_value;
            r_last <= i_last;
        end
        r1_last <= r_last;
        r1_val  <= r_val;
    end

    always_ff @(posedge i_clk) begin
        if (r_valid && (r_type == REQ_LOAD)) begin
            r_vmem[w_addr] <= r_val;
        end
        if (r_valid && (r_type == REQ_NZ)) begin
            r_vec <= r_vmem[w_addr];
        end
    end

    assign o_req     = '{valid: r1_valid, last: r1_last, val: r1_val, vec: r_vec};
    assign o_s0_pend = r_valid && (r_type == REQ_NZ) && r_last;

    a_req_from_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.valid |-> $past(r_valid && (r_type == REQ_NZ)))
        else $error("vector read issued without a nonzero request");

endmodule

/* rtl/core/spmv_mac.sv */
// ----------------------------------------------------------------------------
// spmv_mac
// Product register, 48-bit row accumulator, saturation and row counter.
// ----------------------------------------------------------------------------
module spmv_mac import spmv_pkg::*; #(
    parameter int VECTOR_DEPTH = 4096
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mac_req i_req,
    output t_result  o_res,
    output logic     o_push,
    output logic     o_pend
);

    localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int CW = (AW > IDX_W) ? AW : IDX_W;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pvalid;
    logic                     r_plast;
    logic [ACC_W-1:0]         r_acc;
    logic [CW-1:0]            r_row;

    logic [ACC_W-1:0]         w_sum;
    logic                     w_fits;
    logic                     w_ovf;
    logic signed [VAL_W-1:0]  w_sat;

    assign w_sum  = r_acc + r_prod[PROD_W-1:FRAC_W];
    assign w_fits = (&w_sum[ACC_W-1:VAL_W-1]) || !(|w_sum[ACC_W-1:VAL_W-1]);
    assign w_ovf  = !w_fits;

    always_comb begin
        if (w_fits) begin
            w_sat = w_sum[VAL_W-1:0];
        end else if (w_sum[ACC_W-1]) begin
            w_sat = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= i_req.val * i_req.vec;
        r_plast <= i_req.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
            r_acc    <= '0;
            r_row    <= '0;
        end else begin
            r_pvalid <= i_req.valid;
            if (r_pvalid) begin
                r_acc <= r_plast ? '0 : w_sum;
            end
            if (o_push) begin
                r_row <= (r_row == CW'(VECTOR_DEPTH - 1)) ? '0 : r_row + 1'b1;
            end
        end
    end

    assign o_push = r_pvalid && r_plast;
    assign o_pend = o_push;
    assign o_res  = '{row_index: r_row[IDX_W-1:0], row_sum: w_sat, overflow: w_ovf};

    a_ovf_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_res.overflow) |->
        (o_res.row_sum == {1'b1, {(VAL_W-1){1'b0}}} ||
         o_res.row_sum == {1'b0, {(VAL_W-1){1'b1}}}))
        else $error("overflow flagged on an unclamped sum");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= CW'(VECTOR_DEPTH - 1))
        else $error("row counter beyond vector depth");

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_acc == '0))
        else $error("accumulator not cleared after row end");

endmodule

/* rtl/core/spmv_rfifo.sv */
// ----------------------------------------------------------------------------
// spmv_rfifo
// Result queue between the accumulator and the output stream.
// ----------------------------------------------------------------------------
module spmv_rfifo import spmv_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_result            i_data,
    input  logic               i_pop,
    output t_result            o_data,
    output logic               o_valid,
    output logic [FIFO_CW-1:0] o_count
);

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_CW-1:0] r_count;
    logic               w_pop;

    assign w_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + FIFO_CW'(i_push) - FIFO_CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !w_pop && (r_count == FIFO_CW'(FIFO_DEPTH))))
        else $error("result queue overrun");

endmodule

/* rtl/core/csr_spmv_row_accumulator.sv */
// ----------------------------------------------------------------------------
// csr_spmv_row_accumulator
// CSR sparse matrix-vector row accumulator, signed Q16.16.
//
//   channel   dir  tdata (low bit up)             tuser      tlast
//   s_axis    in   index[11:0], value[43:12]      req_type   last_in_row
//   m_axis    out  row_index[11:0], row_sum[43:12] overflow  -
//
// One request per cycle is taken while s_axis_tready is high; a row result is offered
// on m_axis after its closing nonzero passes the input register, memory read, multiply
// and queue write registers (the accumulate and saturation feed the queue write).
// The vector memory read and the 32x32 multiply each take one registered stage.
// Reset clears the accumulator, row counter and queue; the vector memory is
// not cleared. s_axis_tready drops only while the eight-entry result queue
// could fill with the rows still in flight.
// ----------------------------------------------------------------------------
module csr_spmv_row_accumulator import spmv_pkg::*; #(
    parameter int VECTOR_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // index[11:0], value[43:12], zero[47:44]
    input  logic        s_axis_tuser,   // req_type[0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // row_index[11:0], row_sum[43:12], zero[47:44]
    output logic        m_axis_tuser    // overflow[0]
);

    t_mac_req           w_req;
    t_result            w_res;
    t_result            w_head;
    logic               w_s0_pend;
    logic               w_push;
    logic               w_mac_pend;
    logic [FIFO_CW-1:0] w_count;
    logic [FIFO_CW:0]   w_need;
    logic               w_accept;

    assign w_need = (FIFO_CW+1)'(w_count) + (FIFO_CW+1)'(w_s0_pend)
                  + (FIFO_CW+1)'(w_req.valid && w_req.last) + (FIFO_CW+1)'(w_mac_pend);
    assign s_axis_tready = (w_need < (FIFO_CW+1)'(FIFO_DEPTH));
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    spmv_vec_store #(
        .VECTOR_DEPTH (VECTOR_DEPTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_accept),
        .i_req_type (s_axis_tuser),
        .i_index    (s_axis_tdata[11:0]),
        .i_value    (s_axis_tdata[43:12]),
        .i_last     (s_axis_tlast),
        .o_req      (w_req),
        .o_s0_pend  (w_s0_pend)
    );

    spmv_mac #(
        .VECTOR_DEPTH (VECTOR_DEPTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res),
        .o_push  (w_push),
        .o_pend  (w_mac_pend)
    );

    spmv_rfifo u_rfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .i_pop   (m_axis_tready),
        .o_data  (w_head),
        .o_valid (m_axis_tvalid),
        .o_count (w_count)
    );

    assign m_axis_tdata = {4'b0000, w_head.row_sum, w_head.row_index};
    assign m_axis_tuser = w_head.overflow;

endmodule
